>>> hw/rtl/scma_pkg.sv
// Shared constants and types of the sparse COO matrix-vector accumulate unit.
// Used by the channel interfaces, the multiply-accumulate stage and the top level.
// Depends on nothing.
`timescale 1ns / 1ps

package scma_pkg;

   // Store sizes.
   localparam int NUM_ROWS = 1024;
   localparam int VEC_LEN  = 1024;

   // Address widths of the two stores.
   localparam int ROW_AW = (NUM_ROWS > 1) ? $clog2(NUM_ROWS) : 1;
   localparam int VEC_AW = (VEC_LEN > 1) ? $clog2(VEC_LEN) : 1;

   // Field widths.
   localparam int CMD_W  = 2;
   localparam int IDX_W  = 10;
   localparam int VAL_W  = 16;
   localparam int PROD_W = 2 * VAL_W;
   localparam int ACC_W  = 40;

   // Accumulator limits in Q16.24.
   localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
   localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

   // Command codes.
   typedef enum logic [CMD_W-1:0] {
      CMD_LOAD_VECTOR = 2'd0,
      CMD_PRELOAD_ROW = 2'd1,
      CMD_ACCUMULATE  = 2'd2,
      CMD_READ_ROW    = 2'd3
   } cmd_type;

endpackage

>>> hw/rtl/scma_channels.sv
// Valid/ready channel interfaces for the request and response sides.
// Depends on scma_pkg for the field widths.
`timescale 1ns / 1ps

interface scma_req_if
   import scma_pkg::*;
   ();
   logic                    valid;
   logic                    ready;
   logic [CMD_W-1:0]        command;
   logic [IDX_W-1:0]        row_index;
   logic [IDX_W-1:0]        col_index;
   logic signed [VAL_W-1:0] element_value;
   logic signed [VAL_W-1:0] weight;
   logic signed [ACC_W-1:0] preload_value;

   modport source (
      output valid, command, row_index, col_index, element_value, weight, preload_value,
      input  ready
   );
   modport sink (
      input  valid, command, row_index, col_index, element_value, weight, preload_value,
      output ready
   );
endinterface

interface scma_rsp_if
   import scma_pkg::*;
   ();
   logic                    valid;
   logic                    ready;
   logic [IDX_W-1:0]        out_row;
   logic signed [ACC_W-1:0] row_sum;
   logic                    saturated;

   modport source (
      output valid, out_row, row_sum, saturated,
      input  ready
   );
   modport sink (
      input  valid, out_row, row_sum, saturated,
      output ready
   );
endinterface

>>> hw/rtl/scma_mac.sv
// Multiply-accumulate stage: registered Q8.24 product of Q4.12 operands, then a saturating 40-bit add.
// Depends on scma_pkg.
`timescale 1ns / 1ps

module scma_mac
   import scma_pkg::*;
(
   input  logic                    clock,
   input  logic signed [VAL_W-1:0] vec_value,
   input  logic signed [VAL_W-1:0] weight,
   input  logic signed [ACC_W-1:0] acc_value,
   input  logic                    acc_sat,
   output logic signed [ACC_W-1:0] sum_value,
   output logic                    sum_sat
);

   logic signed [PROD_W-1:0] product_ff;
   logic signed [PROD_W-1:0] product_in;
   logic signed [ACC_W:0]    sum_wide;

   // The product is exact in Q8.24 and registered before the add.
   assign product_in = PROD_W'(vec_value) * PROD_W'(weight);

   always_ff @(posedge clock) begin
      product_ff <= product_in;
   end

   // One guard bit shows overflow; the result clamps and the sticky flag is set.
   always_comb begin
      sum_wide = (ACC_W+1)'(acc_value) + (ACC_W+1)'(product_ff);
      if (sum_wide[ACC_W] != sum_wide[ACC_W-1]) begin
         sum_value = sum_wide[ACC_W] ? ACC_MIN : ACC_MAX;
         sum_sat   = 1'b1;
      end else begin
         sum_value = sum_wide[ACC_W-1:0];
         sum_sat   = acc_sat;
      end
   end

endmodule

>>> hw/rtl/sparse_coo_matvec_accumulate_unit.sv
// Top level of the sparse COO matrix-vector accumulate unit.
// Depends on scma_pkg, scma_channels (scma_req_if, scma_rsp_if) and scma_mac.
`timescale 1ns / 1ps

// Sparse matrix times dense vector over coordinate entries. The dense vector and the
// row accumulators (each with its sticky saturation flag) live in two single-port
// synchronous memories with registered read data. After reset the unit runs a
// clearing pass over every row of the accumulator memory to zero sums and flags and
// accepts no request until it is done. Then one request is handled at a time: a
// vector load or a row preload is a single write; an accumulate goes through memory
// read, registered multiply, saturating add with write-back through the same
// accumulator port; a row read goes through a memory read, then loads the response
// register once the previous response has left it. An unwritten vector element reads
// undefined; an unwritten row reads as zero.
module sparse_coo_matvec_accumulate_unit
   import scma_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   scma_req_if.sink   req_chan,
   scma_rsp_if.source rsp_chan
);

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_MAC_MUL,
      ST_MAC_ADD,
      ST_READ
   } state_type;

   // Control and holding registers.
   state_type               state_ff,     state_in;
   logic [ROW_AW-1:0]       clr_cnt_ff,   clr_cnt_in;
   logic [IDX_W-1:0]        row_ff,       row_in;
   logic                    row_ok_ff,    row_ok_in;
   logic signed [VAL_W-1:0] weight_ff,    weight_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [IDX_W-1:0]        rsp_row_ff,   rsp_row_in;
   logic signed [ACC_W-1:0] rsp_sum_ff,   rsp_sum_in;
   logic                    rsp_sat_ff,   rsp_sat_in;

   // Vector memory.
   logic signed [VAL_W-1:0] vec_mem [VEC_LEN];
   logic                    vec_we;
   logic                    vec_re;
   logic [VEC_AW-1:0]       vec_addr;
   logic signed [VAL_W-1:0] vec_wdata;
   logic signed [VAL_W-1:0] vec_rd_ff;

   // Accumulator memory: saturation flag on top of the 40-bit sum.
   logic [ACC_W:0]          acc_mem [NUM_ROWS];
   logic                    acc_we;
   logic                    acc_re;
   logic [ROW_AW-1:0]       acc_addr;
   logic [ACC_W:0]          acc_wdata;
   logic [ACC_W:0]          acc_rd_ff;

   logic                    req_transfer;
   logic                    req_row_ok;
   logic                    req_col_ok;
   logic signed [ACC_W-1:0] mac_sum;
   logic                    mac_sat;

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign req_transfer   = req_chan.valid && req_chan.ready;
   assign req_row_ok     = 32'(req_chan.row_index) < NUM_ROWS;
   assign req_col_ok     = 32'(req_chan.col_index) < VEC_LEN;

   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.out_row   = rsp_row_ff;
   assign rsp_chan.row_sum   = rsp_sum_ff;
   assign rsp_chan.saturated = rsp_sat_ff;

   scma_mac u_mac (
      .clock     (clock),
      .vec_value (vec_rd_ff),
      .weight    (weight_ff),
      .acc_value (acc_rd_ff[ACC_W-1:0]),
      .acc_sat   (acc_rd_ff[ACC_W]),
      .sum_value (mac_sum),
      .sum_sat   (mac_sat)
   );

   // Sequencer: runs the clearing pass, decodes a request, drives the memory ports and loads the response.
   always_comb begin
      state_in     = state_ff;
      clr_cnt_in   = clr_cnt_ff;
      row_in       = row_ff;
      row_ok_in    = row_ok_ff;
      weight_in    = weight_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_row_in   = rsp_row_ff;
      rsp_sum_in   = rsp_sum_ff;
      rsp_sat_in   = rsp_sat_ff;
      vec_we       = 1'b0;
      vec_re       = 1'b0;
      vec_addr     = VEC_AW'(req_chan.col_index);
      vec_wdata    = req_chan.element_value;
      acc_we       = 1'b0;
      acc_re       = 1'b0;
      acc_addr     = ROW_AW'(req_chan.row_index);
      acc_wdata    = {1'b0, req_chan.preload_value};

      unique case (state_ff)
         ST_CLEAR: begin
            acc_we     = 1'b1;
            acc_addr   = clr_cnt_ff;
            acc_wdata  = '0;
            clr_cnt_in = clr_cnt_ff + ROW_AW'(1);
            if (clr_cnt_ff == ROW_AW'(NUM_ROWS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_transfer) begin
               unique case (cmd_type'(req_chan.command))
                  CMD_LOAD_VECTOR: begin
                     vec_we = req_col_ok;
                  end
                  CMD_PRELOAD_ROW: begin
                     acc_we = req_row_ok;
                  end
                  CMD_ACCUMULATE: begin
                     if (req_row_ok && req_col_ok) begin
                        vec_re    = 1'b1;
                        acc_re    = 1'b1;
                        row_in    = req_chan.row_index;
                        weight_in = req_chan.weight;
                        state_in  = ST_MAC_MUL;
                     end
                  end
                  CMD_READ_ROW: begin
                     acc_re    = req_row_ok;
                     row_in    = req_chan.row_index;
                     row_ok_in = req_row_ok;
                     state_in  = ST_READ;
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_MAC_MUL: begin
            state_in = ST_MAC_ADD;
         end
         ST_MAC_ADD: begin
            acc_we    = 1'b1;
            acc_addr  = ROW_AW'(row_ff);
            acc_wdata = {mac_sat, mac_sum};
            state_in  = ST_IDLE;
         end
         ST_READ: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in = 1'b1;
               rsp_row_in   = row_ff;
               rsp_sum_in   = row_ok_ff ? acc_rd_ff[ACC_W-1:0] : '0;
               rsp_sat_in   = row_ok_ff && acc_rd_ff[ACC_W];
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   // State and registered outputs.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_cnt_ff   <= clr_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      row_ff     <= row_in;
      row_ok_ff  <= row_ok_in;
      weight_ff  <= weight_in;
      rsp_row_ff <= rsp_row_in;
      rsp_sum_ff <= rsp_sum_in;
      rsp_sat_ff <= rsp_sat_in;
   end

   // Vector memory: one port, read data held until the next read.
   always_ff @(posedge clock) begin
      if (vec_we) begin
         vec_mem[vec_addr] <= vec_wdata;
      end
      if (vec_re) begin
         vec_rd_ff <= vec_mem[vec_addr];
      end
   end

   // Accumulator memory: one port, read data held until the next read.
   always_ff @(posedge clock) begin
      if (acc_we) begin
         acc_mem[acc_addr] <= acc_wdata;
      end
      if (acc_re) begin
         acc_rd_ff <= acc_mem[acc_addr];
      end
   end

endmodule

>>> tb/tb.sv
// Testbench for the sparse COO matrix-vector accumulate unit, driven with directed and
// random command streams; each row read-back is checked against behavioural store mirrors.
// Depends on scma_pkg, scma_channels and sparse_coo_matvec_accumulate_unit.
`timescale 1ns / 1ps

module tb;
   import scma_pkg::*;

   // One expected row read-back.
   typedef struct {
      logic [IDX_W-1:0]        row;
      logic signed [ACC_W-1:0] sum;
      logic                    sat;
   } row_readout_type;

   logic clock;
   logic reset;

   scma_req_if req_chan ();
   scma_rsp_if rsp_chan ();

   sparse_coo_matvec_accumulate_unit dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   // Mirrors of the vector store, the row accumulators and their sticky flags.
   logic signed [VAL_W-1:0] vector_mirror [VEC_LEN];
   logic signed [ACC_W-1:0] acc_mirror    [NUM_ROWS];
   bit                      sat_mirror    [NUM_ROWS];

   // Entries written since reset; only these may ever be read.
   bit col_loaded [VEC_LEN];
   bit row_loaded [NUM_ROWS];
   int loaded_cols [$];
   int loaded_rows [$];

   row_readout_type pending_readouts [$];
   int requests_accepted;
   int error_count;
   int send_idle_pct;
   int recv_idle_pct;

   // Free-running clock, 8 ns period.
   initial clock = 1'b0;
   always #4 clock = ~clock;

   // Response side: ready is withdrawn at random according to the current idle rate.
   always @(posedge clock) begin
      rsp_chan.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
   end

   // Applies one accepted request to the mirrors and queues the read-back it causes.
   function automatic void apply_request(cmd_type cmd, logic [IDX_W-1:0] row,
                                         logic [IDX_W-1:0] col,
                                         logic signed [VAL_W-1:0] elem,
                                         logic signed [VAL_W-1:0] wt,
                                         logic signed [ACC_W-1:0] pre);
      logic signed [PROD_W-1:0] prod;
      logic signed [ACC_W:0]    sum;
      row_readout_type          readout;
      case (cmd)
         CMD_LOAD_VECTOR: begin
            if (col < VEC_LEN) begin
               vector_mirror[col] = elem;
               if (!col_loaded[col]) begin
                  col_loaded[col] = 1'b1;
                  loaded_cols.push_back(int'(col));
               end
            end
         end
         CMD_PRELOAD_ROW: begin
            if (row < NUM_ROWS) begin
               acc_mirror[row] = pre;
               sat_mirror[row] = 1'b0;
               if (!row_loaded[row]) begin
                  row_loaded[row] = 1'b1;
                  loaded_rows.push_back(int'(row));
               end
            end
         end
         CMD_ACCUMULATE: begin
            if (row < NUM_ROWS && col < VEC_LEN) begin
               // Exact Q8.24 product, then a saturating add in one extra bit.
               prod = PROD_W'(vector_mirror[col]) * PROD_W'(wt);
               sum  = (ACC_W+1)'(acc_mirror[row]) + (ACC_W+1)'(prod);
               if (sum > ACC_MAX) begin
                  sum             = (ACC_W+1)'(ACC_MAX);
                  sat_mirror[row] = 1'b1;
               end else if (sum < ACC_MIN) begin
                  sum             = (ACC_W+1)'(ACC_MIN);
                  sat_mirror[row] = 1'b1;
               end
               acc_mirror[row] = sum[ACC_W-1:0];
            end
         end
         CMD_READ_ROW: begin
            readout.row = row;
            if (row < NUM_ROWS) begin
               readout.sum = acc_mirror[row];
               readout.sat = sat_mirror[row];
            end else begin
               readout.sum = '0;
               readout.sat = 1'b0;
            end
            pending_readouts.push_back(readout);
         end
      endcase
   endfunction

   // Offers one request, waits for its transfer and updates the mirrors.
   task automatic send_request(input cmd_type cmd, input logic [IDX_W-1:0] row,
                               input logic [IDX_W-1:0] col,
                               input logic signed [VAL_W-1:0] elem,
                               input logic signed [VAL_W-1:0] wt,
                               input logic signed [ACC_W-1:0] pre);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid         <= 1'b1;
      req_chan.command       <= cmd;
      req_chan.row_index     <= row;
      req_chan.col_index     <= col;
      req_chan.element_value <= elem;
      req_chan.weight        <= wt;
      req_chan.preload_value <= pre;
      do @(posedge clock); while (req_chan.ready !== 1'b1);
      apply_request(cmd, row, col, elem, wt, pre);
      requests_accepted++;
   endtask

   // Q4.12 value biased towards the extremes, zero and one.
   function automatic logic signed [VAL_W-1:0] rand_q412();
      case ($urandom_range(0, 7))
         0:       return 16'sh7FFF;
         1:       return 16'sh8000;
         2:       return 16'sh0000;
         3:       return 16'sh1000;
         default: return VAL_W'($urandom);
      endcase
   endfunction

   // Accumulator start value: close to either limit, anywhere, or modest.
   function automatic logic signed [ACC_W-1:0] rand_preload();
      logic signed [31:0] modest;
      logic [ACC_W-1:0]   margin;
      modest = $urandom;
      margin = ACC_W'($urandom_range(0, 32'h7FFF_FFFF));
      case ($urandom_range(0, 5))
         0:       return ACC_MAX - margin;
         1:       return ACC_MIN + margin;
         2:       return ACC_W'({$urandom, $urandom});
         default: return {{(ACC_W-32){modest[31]}}, modest};
      endcase
   endfunction

   function automatic int pick_loaded_col();
      return loaded_cols[$urandom_range(0, loaded_cols.size() - 1)];
   endfunction

   function automatic int pick_loaded_row();
      return loaded_rows[$urandom_range(0, loaded_rows.size() - 1)];
   endfunction

   // Vector elements at both ends of the index range and of the value range.
   task automatic test_vector_extremes();
      send_request(CMD_LOAD_VECTOR, '0, 10'd0,    16'sh7FFF, '0, '0);
      send_request(CMD_LOAD_VECTOR, '0, 10'd1023, 16'sh8000, '0, '0);
      send_request(CMD_LOAD_VECTOR, '0, 10'd512,  16'sh0001, '0, '0);
   endtask

   // Large positive products from both value extremes, and the first and last rows.
   task automatic test_accumulate_extremes();
      send_request(CMD_PRELOAD_ROW, 10'd0, '0, '0, '0, '0);
      send_request(CMD_ACCUMULATE,  10'd0, 10'd0,    '0, 16'sh7FFF, '0);
      send_request(CMD_ACCUMULATE,  10'd0, 10'd1023, '0, 16'sh8000, '0);
      send_request(CMD_READ_ROW,    10'd0, '0, '0, '0, '0);
      send_request(CMD_PRELOAD_ROW, 10'd1023, '0, '0, '0, ACC_MIN);
      send_request(CMD_ACCUMULATE,  10'd1023, 10'd512, '0, 16'sh0001, '0);
      send_request(CMD_READ_ROW,    10'd1023, '0, '0, '0, '0);
   endtask

   // Clamping at both limits, stickiness of the flag, and its clearing by a preload.
   task automatic test_saturation_flag();
      send_request(CMD_PRELOAD_ROW, 10'd5, '0, '0, '0, ACC_MAX - 40'sd5);
      send_request(CMD_ACCUMULATE,  10'd5, 10'd0, '0, 16'sh7FFF, '0);
      send_request(CMD_READ_ROW,    10'd5, '0, '0, '0, '0);
      send_request(CMD_ACCUMULATE,  10'd5, 10'd0, '0, 16'sh8000, '0);
      send_request(CMD_READ_ROW,    10'd5, '0, '0, '0, '0);
      send_request(CMD_PRELOAD_ROW, 10'd6, '0, '0, '0, ACC_MIN + 40'sd3);
      send_request(CMD_ACCUMULATE,  10'd6, 10'd0, '0, 16'sh8000, '0);
      send_request(CMD_READ_ROW,    10'd6, '0, '0, '0, '0);
      send_request(CMD_PRELOAD_ROW, 10'd5, '0, '0, '0, ACC_MAX);
      send_request(CMD_READ_ROW,    10'd5, '0, '0, '0, '0);
   endtask

   // Mostly complete matrix-vector passes with random content, some loose commands.
   // Accumulates and reads only ever touch entries that have been written.
   task automatic test_random_matvec(input int stop_at);
      cmd_type          cmd;
      logic [IDX_W-1:0] row;
      logic [IDX_W-1:0] col;
      int               r;
      int               nonzeros;
      while (requests_accepted < stop_at) begin
         if ($urandom_range(0, 4) == 0) begin
            // A short burst of loose commands with random fields; accumulates and reads use written entries.
            repeat ($urandom_range(1, 5)) begin
               cmd = cmd_type'($urandom_range(0, 3));
               row = IDX_W'($urandom);
               col = IDX_W'($urandom);
               if (cmd == CMD_ACCUMULATE) begin
                  row = IDX_W'(pick_loaded_row());
                  col = IDX_W'(pick_loaded_col());
               end else if (cmd == CMD_READ_ROW) begin
                  row = IDX_W'(pick_loaded_row());
               end
               send_request(cmd, row, col, rand_q412(), rand_q412(), rand_preload());
            end
         end else begin
            // Load a few vector elements, then stream row-sorted entries and read back.
            repeat ($urandom_range(1, 8)) begin
               send_request(CMD_LOAD_VECTOR, IDX_W'($urandom),
                            IDX_W'($urandom_range(0, VEC_LEN - 1)),
                            rand_q412(), VAL_W'($urandom), rand_preload());
            end
            r = $urandom_range(0, NUM_ROWS - 1);
            repeat ($urandom_range(1, 4)) begin
               // Either start the row afresh or keep adding onto a row that holds a sum.
               if ($urandom_range(0, 3) != 0) begin
                  send_request(CMD_PRELOAD_ROW, IDX_W'(r), IDX_W'($urandom),
                               VAL_W'($urandom), VAL_W'($urandom), rand_preload());
               end else begin
                  r = pick_loaded_row();
               end
               nonzeros = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40)
                                                      : $urandom_range(1, 8);
               repeat (nonzeros) begin
                  send_request(CMD_ACCUMULATE, IDX_W'(r), IDX_W'(pick_loaded_col()),
                               VAL_W'($urandom), rand_q412(),
                               ACC_W'({$urandom, $urandom}));
               end
               send_request(CMD_READ_ROW, IDX_W'(r), IDX_W'($urandom), VAL_W'($urandom),
                            VAL_W'($urandom), ACC_W'({$urandom, $urandom}));
               r = (r + $urandom_range(1, 64)) % NUM_ROWS;
            end
         end
      end
   endtask

   // Each response transfer is compared with the oldest outstanding read-back.
   // Reporting is capped so that a broken unit cannot flood the log.
   always @(posedge clock) begin
      row_readout_type want;
      if (rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1) begin
         if (pending_readouts.size() == 0) begin
            if (error_count < 30)
               $display("%0t: unexpected response, expected none, actual row %0d",
                        $time, rsp_chan.out_row);
            error_count++;
         end else begin
            want = pending_readouts.pop_front();
            if (rsp_chan.out_row !== want.row) begin
               if (error_count < 30)
                  $display("%0t: out_row expected %0d actual %0d",
                           $time, want.row, rsp_chan.out_row);
               error_count++;
            end
            if (rsp_chan.row_sum !== want.sum) begin
               if (error_count < 30)
                  $display("%0t: row %0d row_sum expected %0d actual %0d",
                           $time, want.row, want.sum, rsp_chan.row_sum);
               error_count++;
            end
            if (rsp_chan.saturated !== want.sat) begin
               if (error_count < 30)
                  $display("%0t: row %0d saturated expected %0b actual %0b",
                           $time, want.row, want.sat, rsp_chan.saturated);
               error_count++;
            end
         end
      end
   end

   // Main sequence.
   initial begin
      reset                  <= 1'b1;
      req_chan.valid         <= 1'b0;
      req_chan.command       <= CMD_LOAD_VECTOR;
      req_chan.row_index     <= '0;
      req_chan.col_index     <= '0;
      req_chan.element_value <= '0;
      req_chan.weight        <= '0;
      req_chan.preload_value <= '0;
      send_idle_pct = 20;
      recv_idle_pct = 72;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // The unit clears its sums and flags after reset; the first transfer simply waits for it.
      test_vector_extremes();
      test_accumulate_extremes();
      test_saturation_flag();
      test_random_matvec(requests_accepted + 510);

      send_idle_pct = 72;
      recv_idle_pct = 20;
      test_random_matvec(requests_accepted + 510);

      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_random_matvec(requests_accepted + 510);

      // Drain: wait for every read-back, then let a trailing accumulate settle.
      req_chan.valid <= 1'b0;
      while (pending_readouts.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (error_count == 0)
         $display("tb passed");
      else
         $display("tb failed");
      $finish;
   end

   // Watchdog well beyond the slowest legal run.
   initial begin
      #5_000_000;
      $display("tb failed");
      $finish;
   end

endmodule

>>> sparse_coo_matvec_accumulate_unit.f
hw/rtl/scma_pkg.sv
hw/rtl/scma_channels.sv
hw/rtl/scma_mac.sv
hw/rtl/sparse_coo_matvec_accumulate_unit.sv
tb/tb.sv
